>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int FUNC_W   = 1;
  localparam int REQ_W    = 24;
  localparam int NODE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OFF_W    = 23;
  localparam int SIZE_W   = 24;
  localparam int MINB_W   = 17;
  localparam int HDR_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_BLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOOBIG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REQ_W-1:0]  request_bytes;
    logic [NODE_W-1:0] free_node;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node_index;
    logic [OFF_W-1:0]    byte_offset;
    logic [SIZE_W-1:0]   block_bytes;
  } rsp_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIT, S_SCAN, S_SCAN_CHK, S_SPLIT,
    S_FR_SELF, S_FR_ANC, S_FR_SUB, S_FR_SUB_CHK, S_MERGE_RD, S_MERGE_CHK, S_OUT
  } state_t;

endpackage

>>> rtl/bba_if.sv
// ----------------------------------------------------------------------------
// bba_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface bba_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bba_mark_mem.sv
// ----------------------------------------------------------------------------
// bba_mark_mem
// Free-mark store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_mark_mem #(
  parameter int DEPTH = 255,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a binary tree of free marks held in one memory.
// ----------------------------------------------------------------------------
// Channels: req (func, request_bytes, free_node), rsp (status, node_index,
// byte_offset, block_bytes) and cfg (index, value). One response word per
// request word, in order; one request is in flight at a time.
// The marks live in one memory of 2^LEVELS-1 entries with a registered read,
// so the time to a response follows the walks:
//   alloc: a fit step per level tried, then a read and a check per node
//          scanned, then a split step per level descended and a final one.
//   free : an own check, a step per ancestor, a subtree setup, a step per
//          subtree node, then a read and a check per sibling on the merge
//          walk, and a final step if it reaches the root.
// req goes ready again once the response word is taken and the core has
// moved from S_OUT back to S_IDLE.
// After reset a clearing pass writes every entry (root marked) while req is
// held not ready; cfg writes are taken at any time.
// A stalled rsp holds its word; the next request waits behind it.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core #(
  parameter int LEVELS = 8
) (
  input logic clk,
  input logic rst,
  bba_if.sink   req,
  bba_if.source rsp,
  bba_if.sink   cfg
);
  import bba_pkg::*;

  localparam int NODES = (1 << LEVELS) - 1;
  localparam int AW    = LEVELS;
  localparam int LW    = $clog2(LEVELS + 1);
  localparam int CW    = (AW > NODE_W) ? AW : NODE_W;

  logic [MINB_W-1:0] min_block;
  logic [HDR_W-1:0]  hdr;

  state_t state, state_next;

  logic [AW-1:0]     addr;       // current node
  logic [AW-1:0]     orig;       // node of the free request
  logic [AW-1:0]     last;       // scan / subtree range end
  logic [AW-1:0]     first;
  logic [LW-1:0]     lvl;        // level of current scan
  logic [LW-1:0]     fit;
  logic [REQ_W:0]    need;
  logic [SIZE_W+16:0] blk;       // candidate block size, wide
  logic              fr_func;
  logic [NODE_W-1:0] fr_node;
  logic [AW-1:0]     mnode;      // node whose mark the merge walk carries

  logic              rsp_valid;
  logic [STATUS_W-1:0] o_status;
  logic [NODE_W-1:0] o_node;
  logic [OFF_W-1:0]  o_off;
  logic [SIZE_W-1:0] o_size;

  logic          we, wdata, rdata;
  logic [AW-1:0] waddr, raddr;

  bba_mark_mem #(.DEPTH(NODES), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_block <= MINB_W'(64);
      hdr       <= HDR_W'(8);
    end else if (cfg.valid) begin
      if (cfg.data.index == REG_MIN_BLOCK) min_block <= cfg.data.value[MINB_W-1:0];
      else                                 hdr <= cfg.data.value[HDR_W-1:0];
    end
  end

  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.data.status      = o_status;
  assign rsp.data.node_index  = o_node;
  assign rsp.data.byte_offset = o_off;
  assign rsp.data.block_bytes = o_size;

  function automatic logic [AW-1:0] lvl_start(input logic [LW-1:0] l);
    lvl_start = AW'((1 << l) - 1);
  endfunction

  logic [AW:0]   a2p1, a2p2;
  assign a2p1 = {addr, 1'b1};
  assign a2p2 = {addr, 1'b0} + (AW+1)'(2);
  logic [AW-1:0] par;
  assign par = AW'((addr - AW'(1)) >> 1);

  logic [AW:0]   c2p1, c2p2;     // children of the freed node
  assign c2p1 = {orig, 1'b1};
  assign c2p2 = {orig, 1'b0} + (AW+1)'(2);

  logic [AW:0]   f2, l2;
  assign f2 = {first, 1'b1};
  assign l2 = {last, 1'b0} + (AW+1)'(2);

  logic [AW-1:0] sib, mpar;
  assign sib  = mnode[0] ? mnode + AW'(1) : mnode - AW'(1);
  assign mpar = AW'((mnode - AW'(1)) >> 1);

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  logic finish;
  logic [STATUS_W-1:0] fin_st;

  always_comb begin
    state_next = state;
    we = 1'b0; waddr = addr; wdata = 1'b0; raddr = addr;
    finish = 1'b0; fin_st = ST_OK;
    case (state)
      S_CLEAR: begin
        we = 1'b1; wdata = (addr == '0);
        if (addr == AW'(NODES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && req.ready) state_next = (req.data.func == FUNC_ALLOC) ? S_FIT : S_FR_SELF;
        raddr = AW'(req.data.free_node);
      end
      S_FIT: begin
        if (blk >= (SIZE_W+17)'(need)) begin
          state_next = S_SCAN; raddr = lvl_start(fit);
        end else if (fit == '0) begin
          finish = 1'b1; fin_st = ST_TOOBIG; state_next = S_OUT;
        end
      end
      S_SCAN: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (rdata) begin
          we = 1'b1; wdata = 1'b0;
          state_next = S_SPLIT;
        end else if (addr != last) begin
          raddr = addr + AW'(1); state_next = S_SCAN;
        end else if (lvl == '0) begin
          finish = 1'b1; fin_st = ST_NOMEM; state_next = S_OUT;
        end else begin
          raddr = lvl_start(lvl - LW'(1)); state_next = S_SCAN;
        end
      end
      S_SPLIT: begin
        if (lvl == fit) begin
          finish = 1'b1; state_next = S_OUT;
        end else begin
          we = 1'b1; wdata = 1'b1; waddr = a2p2[AW-1:0];
        end
      end
      S_FR_SELF: begin
        if (CW'(fr_node) >= CW'(NODES) || rdata) begin
          finish = 1'b1; fin_st = ST_BADIDX; state_next = S_OUT;
        end else if (addr == '0) begin
          state_next = S_FR_SUB;
        end else begin
          raddr = par; state_next = S_FR_ANC;
        end
      end
      S_FR_ANC: begin
        // rdata is the mark of addr, read last cycle
        if (rdata) begin
          finish = 1'b1; fin_st = ST_BADIDX; state_next = S_OUT;
        end else if (addr == '0) begin
          state_next = S_FR_SUB;
        end else begin
          raddr = par;
        end
      end
      S_FR_SUB: begin
        if (c2p1 > (AW+1)'(NODES - 1)) begin
          state_next = S_MERGE_RD;
        end else begin
          raddr = c2p1[AW-1:0]; state_next = S_FR_SUB_CHK;
        end
      end
      S_FR_SUB_CHK: begin
        if (rdata) begin
          finish = 1'b1; fin_st = ST_BADIDX; state_next = S_OUT;
        end else if (addr != last) begin
          raddr = addr + AW'(1);
        end else if (f2 > (AW+1)'(NODES - 1)) begin
          state_next = S_MERGE_RD;
        end else begin
          raddr = f2[AW-1:0];
        end
      end
      // The carried mark is written only where the walk stops; each merged
      // sibling is cleared on the way up.
      S_MERGE_RD: begin
        if (mnode == '0) begin
          we = 1'b1; wdata = 1'b1; waddr = mnode;
          finish = 1'b1; state_next = S_OUT;
        end else begin
          raddr = sib; state_next = S_MERGE_CHK;
        end
      end
      S_MERGE_CHK: begin
        if (rdata) begin
          we = 1'b1; wdata = 1'b0; waddr = sib; state_next = S_MERGE_RD;
        end else begin
          we = 1'b1; wdata = 1'b1; waddr = mnode;
          finish = 1'b1; state_next = S_OUT;
        end
      end
      S_OUT: if (!rsp_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0; rsp_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        S_CLEAR: addr <= (addr == AW'(NODES - 1)) ? '0 : addr + AW'(1);
        S_IDLE: if (req.valid && req.ready) begin
          fr_func <= req.data.func;
          fr_node <= req.data.free_node;
          addr <= AW'(req.data.free_node);
          orig <= AW'(req.data.free_node);
          need <= (REQ_W+1)'(req.data.request_bytes) + (REQ_W+1)'(hdr);
          fit <= LW'(LEVELS - 1);
          blk <= (SIZE_W+17)'(min_block);
        end
        S_FIT: begin
          if (blk >= (SIZE_W+17)'(need)) begin
            lvl <= fit; addr <= lvl_start(fit);
            last <= AW'((1 << (fit + LW'(1))) - 2);
          end else begin
            fit <= fit - LW'(1); blk <= blk << 1;
          end
        end
        S_SCAN_CHK: begin
          if (rdata) begin
            // keep addr
          end else if (addr != last) addr <= addr + AW'(1);
          else if (lvl != '0) begin
            lvl <= lvl - LW'(1); addr <= lvl_start(lvl - LW'(1));
            last <= lvl_start(lvl) - AW'(1);
          end
        end
        S_SPLIT: if (lvl != fit) begin
          addr <= a2p1[AW-1:0]; lvl <= lvl + LW'(1);
        end
        S_FR_SELF: if (addr != '0) addr <= par;
        S_FR_ANC:  if (addr != '0) addr <= par;
        S_FR_SUB: begin
          mnode <= orig;
          first <= c2p1[AW-1:0]; last <= c2p2[AW-1:0]; addr <= c2p1[AW-1:0];
        end
        S_FR_SUB_CHK: begin
          if (addr != last) addr <= addr + AW'(1);
          else if (f2 <= (AW+1)'(NODES - 1)) begin
            first <= f2[AW-1:0]; last <= l2[AW-1:0]; addr <= f2[AW-1:0];
          end
        end
        S_MERGE_CHK: if (rdata) mnode <= mpar;
        default: ;
      endcase
      if (finish) begin
        rsp_valid <= 1'b1;
        o_status <= fin_st;
        o_node <= '0; o_off <= '0; o_size <= '0;
        if (fin_st == ST_OK && fr_func == FUNC_ALLOC) begin
          o_node <= NODE_W'(addr);
          o_size <= blk[SIZE_W-1:0];
          o_off  <= blk[OFF_W-1:0] * OFF_W'(addr - lvl_start(fit));
        end
      end
    end
  end
endmodule

>>> tb/buddy_block_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_tb
// Self-checking bench for the buddy allocator core. A behavioral model of the
// free-mark tree predicts every response word. Directed cases cover the edge
// cases, then random alloc/free traffic runs under several register settings.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int NLEV  = 8;
  localparam int NODES = (1 << NLEV) - 1;
  localparam longint CYCLE_LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bba_if #(.T(req_word_t)) req ();
  bba_if #(.T(rsp_word_t)) rsp ();
  bba_if #(.T(cfg_word_t)) cfg ();

  buddy_block_allocator_core #(.LEVELS(NLEV)) u_top (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  bit [NODES-1:0] marks;
  int unsigned    min_block;
  int unsigned    hdr_bytes;
  rsp_word_t      rsp_expected_q[$];
  int unsigned    held_nodes[$];
  int             errors = 0;
  int             burst_left = 0;
  bit             hold_on = 1'b0;
  event           hold_ev;
  longint         cycles = 0;

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    rsp.ready = 1'b0;
  end

  function automatic bit subtree_marked(int unsigned n);
    int unsigned first, last;
    first = n;
    last  = n;
    forever begin
      first = 2 * first + 1;
      last  = 2 * last + 2;
      if (first >= NODES) return 1'b0;
      for (int unsigned i = first; i <= last && i < NODES; i++)
        if (marks[i]) return 1'b1;
    end
  endfunction

  function automatic rsp_word_t tree_alloc(longint unsigned need);
    rsp_word_t r;
    int fit, found;
    longint unsigned blk, b;
    int unsigned n;
    r = '0;
    fit = -1;
    blk = 0;
    for (int l = NLEV - 1; l >= 0; l--) begin
      b = longint'(min_block) << (NLEV - 1 - l);
      if (b >= need) begin
        fit = l;
        blk = b;
        break;
      end
    end
    if (fit < 0) begin
      r.status = ST_TOOBIG;
      return r;
    end
    found = -1;
    n = 0;
    for (int l = fit; l >= 0 && found < 0; l--)
      for (int unsigned i = (1 << l) - 1; i < (1 << (l + 1)) - 1; i++)
        if (marks[i]) begin
          n = i;
          found = l;
          break;
        end
    if (found < 0) begin
      r.status = ST_NOMEM;
      return r;
    end
    marks[n] = 1'b0;
    while (found < fit) begin
      marks[2 * n + 2] = 1'b1;
      n = 2 * n + 1;
      found++;
    end
    r.status      = ST_OK;
    r.node_index  = n[NODE_W-1:0];
    r.byte_offset = OFF_W'(blk * (n - ((1 << fit) - 1)));
    r.block_bytes = SIZE_W'(blk);
    held_nodes.push_back(n);
    return r;
  endfunction

  function automatic rsp_word_t tree_free(int unsigned n);
    rsp_word_t r;
    int unsigned a, p, orig;
    r = '0;
    r.status = ST_BADIDX;
    orig = n;
    if (n >= NODES || marks[n]) return r;
    a = n;
    while (a != 0) begin
      a = (a - 1) / 2;
      if (marks[a]) return r;
    end
    if (subtree_marked(n)) return r;
    marks[n] = 1'b1;
    while (n != 0) begin
      p = (n - 1) / 2;
      if (!(marks[2 * p + 1] && marks[2 * p + 2])) break;
      marks[p] = 1'b1;
      marks[2 * p + 1] = 1'b0;
      marks[2 * p + 2] = 1'b0;
      n = p;
    end
    r.status = ST_OK;
    for (int i = 0; i < held_nodes.size(); i++)
      if (held_nodes[i] == orig) begin
        held_nodes.delete(i);
        break;
      end
    return r;
  endfunction

  // sender: bursts of random length, most of them preceded by a random gap
  task automatic send_word(req_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    req.valid <= 1'b1;
    req.data  <= w;
    do @(posedge clk); while (!(req.valid && req.ready));
    if (w.func == FUNC_ALLOC)
      rsp_expected_q.push_back(tree_alloc(longint'(w.request_bytes) + hdr_bytes));
    else
      rsp_expected_q.push_back(tree_free(w.free_node));
  endtask

  task automatic send_alloc(int unsigned bytes);
    req_word_t w;
    w.func          = FUNC_ALLOC;
    w.request_bytes = bytes[REQ_W-1:0];
    w.free_node     = NODE_W'($urandom);
    send_word(w);
  endtask

  task automatic send_free(int unsigned n);
    req_word_t w;
    w.func          = FUNC_FREE;
    w.request_bytes = REQ_W'($urandom);
    w.free_node     = n[NODE_W-1:0];
    send_word(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    req.valid <= 1'b0;
    wait (rsp_expected_q.size() == 0);
    repeat (4) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= '{index: idx, value: val[CFG_DATA_W-1:0]};
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    cfg.valid <= 1'b0;
    if (idx == REG_MIN_BLOCK) min_block = val & 32'h1FFFF;
    else hdr_bytes = val & 32'h7F;
  endtask

  task automatic set_config(int unsigned minb, int unsigned hdr);
    write_reg(REG_MIN_BLOCK, minb);
    write_reg(REG_HEADER, hdr);
  endtask

  // a held node may already be gone through a free of an enclosing or inner
  // node; each one is tried once
  task automatic release_all();
    int unsigned n;
    while (held_nodes.size() > 0) begin
      n = held_nodes.pop_front();
      send_free(n);
    end
  endtask

  // long receiver hold-off, counted here
  initial begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk);
    hold_on <= 1'b0;
  end

  // response checker with its own stall pattern
  int rx_mode = 0;
  always @(posedge clk) begin
    rsp_word_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (rsp_expected_q.size() == 0) begin
        $display("%0t: response word with none expected: %p", $time, rsp.data);
        errors <= errors + 1;
      end else begin
        e = rsp_expected_q.pop_front();
        if (rsp.data !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, rsp.data);
          errors <= errors + 1;
        end
      end
    end
    if (cycles % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_on) begin
      rsp.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 1) == 1);
        2: rsp.ready <= (cycles % 4 == 0);
        default: rsp.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic test_directed();
    send_alloc(64 * 128 - 8);            // whole pool, gets the root
    send_alloc(0);                       // nothing left
    send_free(0);                        // good free of root
    send_free(0);                        // already marked
    send_alloc(0);                       // deepest block, splits all the way
    send_free(0);                        // holds marked descendants
    send_free(5);                        // marked ancestor
    send_free(2);                        // already marked
    send_free(255);                      // beyond the tree
    send_alloc(24'hFFFFFF);              // too large
    send_alloc(64 * 128 - 7);            // just over the pool
    send_alloc(100);
    send_alloc(1000);
    send_alloc(56);
    release_all();
  endtask

  task automatic test_random(int count);
    int unsigned n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 5) begin
        case ($urandom_range(0, 9))
          0: send_alloc($urandom);
          1: send_alloc($urandom_range(0, 255));
          default: send_alloc($urandom_range(0, min_block << $urandom_range(0, NLEV - 1)));
        endcase
      end else if (held_nodes.size() > 0 && $urandom_range(0, 9) < 8) begin
        n = $urandom_range(0, held_nodes.size() - 1);
        send_free(held_nodes[n]);
      end else begin
        send_free($urandom_range(0, 255));
      end
    end
    release_all();
  endtask

  task automatic test_backpressure();
    -> hold_ev;
    for (int i = 0; i < 20; i++) send_alloc($urandom_range(0, 200));
    release_all();
  endtask

  initial begin
    min_block = 64;
    hdr_bytes = 8;
    marks = '0;
    marks[0] = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(200);
    set_config(8, 0);
    test_random(200);
    set_config(65536, 64);
    test_random(200);
    set_config(0, 127);                  // zero smallest block, widest header
    send_alloc(0);
    test_random(80);
    set_config(0, 0);
    send_alloc(0);
    send_alloc(1);
    test_random(80);
    set_config(17'h1FFFF, 127);          // offsets wrap at field width
    test_random(200);
    set_config(64, 8);
    test_random(160);
    req.valid <= 1'b0;
    wait (rsp_expected_q.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
